// ----- hdl/cma_pkg.sv -----
// cma_pkg: shared types and constants for the centered moving average block.
// Used by cma_front, cma_queue, cma_back and centered_moving_average_top.
package cma_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int SUM_W         = 39;
	localparam int CNT_W         = 7;
	localparam int CFG_W         = 7;
	localparam int DEF_MAX_HALF  = 32;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [APB_ADDR_W-3:0] REG_WINDOW_SIZE = '0;
	localparam logic [CFG_W-1:0]      WINDOW_SIZE_RST = CFG_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       series_end;
	} cma_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] average;
		logic                       final_result;
	} cma_result_t;

	// one division job: window sum, divisor and end-of-series mark
	typedef struct packed {
		logic signed [SUM_W-1:0] total;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} cma_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cma_qstat_t;

endpackage

// ----- hdl/cma_front.sv -----
// cma_front: accepts samples, keeps the sample ring and running window sum,
// and issues one division job per result. Depends on cma_pkg.
module cma_front #(
	parameter int MAX_HALF = cma_pkg::DEF_MAX_HALF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cma_pkg::CFG_W-1:0]     window_size,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  cma_pkg::cma_item_t            item,
	input  cma_pkg::cma_qstat_t           q_stat,
	output logic                          job_push,
	output cma_pkg::cma_job_t             job
);
	import cma_pkg::*;

	localparam int RING_DEPTH = 2 * MAX_HALF + 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int HALF_W     = $clog2(MAX_HALF + 1);
	localparam int SEEN_W     = $clog2(MAX_HALF + 2);
	localparam int HW_W       = CFG_W - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_SUB,
		ST_INSERT,
		ST_TRIM,
		ST_TRIM_SUB,
		ST_EMIT,
		ST_MAIN_DONE
	} state_t;

	state_t                     state_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       end_q;
	logic [HALF_W-1:0]          half_q;
	logic signed [SUM_W-1:0]    total_q;
	logic [CNT_W-1:0]           siw_q;
	logic [SEEN_W-1:0]          seen_q;
	logic [PTR_W-1:0]           head_q;
	logic [HALF_W-1:0]          k_q;
	logic [CNT_W-1:0]           limit_q;
	logic                       flush_q;
	logic                       last_q;

	logic signed [SAMPLE_W-1:0] ring_q [RING_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_data_q;

	logic [HW_W-1:0]   ws_half;
	logic [HALF_W-1:0] half_c;
	logic [PTR_W:0]    idx_wide;
	logic [PTR_W-1:0]  oldest_idx;
	logic [SEEN_W-1:0] half_p1;
	logic [HALF_W-1:0] pending_c;
	logic              ring_we;

	always_comb begin
		ws_half = window_size[CFG_W-1:1];
		if (ws_half > HW_W'(MAX_HALF)) begin
			half_c = HALF_W'(MAX_HALF);
		end else begin
			half_c = HALF_W'(ws_half);
		end
	end

	always_comb begin
		idx_wide = (PTR_W+1)'(head_q) + (PTR_W+1)'(RING_DEPTH) - (PTR_W+1)'(siw_q);
		if (idx_wide >= (PTR_W+1)'(RING_DEPTH)) begin
			oldest_idx = PTR_W'(idx_wide - (PTR_W+1)'(RING_DEPTH));
		end else begin
			oldest_idx = PTR_W'(idx_wide);
		end
	end

	assign half_p1   = SEEN_W'(half_q) + SEEN_W'(1);
	assign pending_c = (seen_q > SEEN_W'(half_q)) ? half_q : HALF_W'(seen_q);
	assign ring_we   = (state_q == ST_INSERT);

	assign item_stall = (state_q != ST_IDLE);
	assign job_push   = (state_q == ST_EMIT) && !q_stat.full;
	assign job.total  = total_q;
	assign job.count  = siw_q;
	assign job.last   = last_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[head_q] <= sample_q;
		end
		rd_data_q <= ring_q[oldest_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sample_q <= '0;
			end_q    <= 1'b0;
			half_q   <= '0;
			total_q  <= '0;
			siw_q    <= '0;
			seen_q   <= '0;
			head_q   <= '0;
			k_q      <= '0;
			limit_q  <= '0;
			flush_q  <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						sample_q <= item.sample;
						end_q    <= item.series_end;
						half_q   <= half_c;
						if (siw_q == CNT_W'(RING_DEPTH)) begin
							state_q <= ST_PRE_SUB;
						end else begin
							state_q <= ST_INSERT;
						end
					end
				end
				ST_PRE_SUB: begin
					total_q <= total_q - SUM_W'(rd_data_q);
					siw_q   <= siw_q - CNT_W'(1);
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					head_q  <= (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
					siw_q   <= siw_q + CNT_W'(1);
					total_q <= total_q + SUM_W'(sample_q);
					seen_q  <= (seen_q < half_p1) ? seen_q + SEEN_W'(1) : half_p1;
					limit_q <= CNT_W'({half_q, 1'b1});
					flush_q <= 1'b0;
					state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (siw_q > limit_q) begin
						state_q <= ST_TRIM_SUB;
					end else if (flush_q) begin
						last_q  <= (k_q == HALF_W'(1));
						state_q <= ST_EMIT;
					end else if (seen_q == half_p1) begin
						last_q  <= end_q && (half_q == '0);
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_MAIN_DONE;
					end
				end
				ST_TRIM_SUB: begin
					total_q <= total_q - SUM_W'(rd_data_q);
					siw_q   <= siw_q - CNT_W'(1);
					state_q <= ST_TRIM;
				end
				ST_EMIT: begin
					if (!q_stat.full) begin
						if (!flush_q) begin
							state_q <= ST_MAIN_DONE;
						end else if (k_q == HALF_W'(1)) begin
							total_q <= '0;
							siw_q   <= '0;
							seen_q  <= '0;
							head_q  <= '0;
							flush_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q - HALF_W'(1);
							limit_q <= CNT_W'(k_q) - CNT_W'(1) + CNT_W'(half_q);
							state_q <= ST_TRIM;
						end
					end
				end
				ST_MAIN_DONE: begin
					if (end_q && pending_c != '0) begin
						k_q     <= pending_c;
						limit_q <= CNT_W'(pending_c) + CNT_W'(half_q);
						flush_q <= 1'b1;
						state_q <= ST_TRIM;
					end else if (end_q) begin
						total_q <= '0;
						siw_q   <= '0;
						seen_q  <= '0;
						head_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/cma_queue.sv -----
// cma_queue: small FIFO of division jobs between front and back.
// Depends on cma_pkg.
module cma_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cma_pkg::cma_job_t    push_job,
	input  logic                 pop,
	output cma_pkg::cma_job_t    head_job,
	output cma_pkg::cma_qstat_t  stat
);
	import cma_pkg::*;

	cma_job_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/cma_back.sv -----
// cma_back: radix-2 restoring divider (signed sum by count, truncating)
// and the result output register. Depends on cma_pkg.
module cma_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cma_pkg::cma_qstat_t   q_stat,
	input  cma_pkg::cma_job_t     job,
	output logic                  job_pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output cma_pkg::cma_result_t  result
);
	import cma_pkg::*;

	localparam int ITER_W = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DONE
	} state_t;

	state_t             state_q;
	logic [SUM_W-1:0]   quot_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [ITER_W-1:0]  iter_q;
	logic               neg_q;
	logic               last_q;
	logic               valid_q;
	cma_result_t        result_q;

	logic [SUM_W-1:0]   mag_c;
	logic [CNT_W:0]     trial_c;
	logic               ge_c;
	logic [SUM_W-1:0]   signed_quot_c;
	logic               out_free;

	assign mag_c         = job.total[SUM_W-1] ? SUM_W'(-job.total) : SUM_W'(job.total);
	assign trial_c       = {rem_q, quot_q[SUM_W-1]};
	assign ge_c          = (trial_c >= {1'b0, div_q});
	assign signed_quot_c = neg_q ? -quot_q : quot_q;
	assign out_free      = !valid_q || !result_stall;

	assign job_pop      = (state_q == B_IDLE) && !q_stat.empty;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			quot_q   <= '0;
			rem_q    <= '0;
			div_q    <= '0;
			iter_q   <= '0;
			neg_q    <= 1'b0;
			last_q   <= 1'b0;
			valid_q  <= 1'b0;
			result_q <= '0;
		end else begin
			if ((state_q == B_DONE) && out_free) begin
				valid_q <= 1'b1;
			end else if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						quot_q  <= mag_c;
						rem_q   <= '0;
						div_q   <= job.count;
						neg_q   <= job.total[SUM_W-1];
						last_q  <= job.last;
						iter_q  <= ITER_W'(SUM_W);
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					rem_q  <= ge_c ? CNT_W'(trial_c - {1'b0, div_q}) : CNT_W'(trial_c);
					quot_q <= {quot_q[SUM_W-2:0], ge_c};
					iter_q <= iter_q - ITER_W'(1);
					if (iter_q == ITER_W'(1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						result_q.average      <= (div_q == '0) ? '0
							: SAMPLE_W'(signed_quot_c);
						result_q.final_result <= last_q;
						state_q               <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/centered_moving_average_top.sv -----
// Centered moving average: a sample front end and a divider back end joined by a
// four-word job queue, and the APB window_size register. An accepted sample
// holds the input while the front inserts it into the ring, first subtracting
// the oldest sample of a full ring, trims the window and emits a word when one
// is due; a flush at series end trims and emits each pending word in turn, and a
// full queue stretches each emit. Each result word then goes through the 39-step
// restoring divider, which starts the next word only once it is done with the last.
// The front keeps up to four words ahead of the divider, and the output register
// lets the divider start on the next word while a result waits. The sample ring
// holds 2*MAX_HALF+1 words and needs no clearing after reset.
module centered_moving_average_top #(
	parameter int MAX_HALF = cma_pkg::DEF_MAX_HALF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  cma_pkg::cma_item_t                 item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output cma_pkg::cma_result_t               result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cma_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [cma_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [cma_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import cma_pkg::*;

	logic [CFG_W-1:0] window_size_q;
	logic             reg_hit;
	logic             job_push;
	logic             job_pop;
	cma_job_t         push_job;
	cma_job_t         head_job;
	cma_qstat_t       q_stat;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE);
	assign prdata  = reg_hit ? APB_DATA_W'(window_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			window_size_q <= pwdata[CFG_W-1:0];
		end
	end

	cma_front #(
		.MAX_HALF (MAX_HALF)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (window_size_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.q_stat      (q_stat),
		.job_push    (job_push),
		.job         (push_job)
	);

	cma_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	cma_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.job          (head_job),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_stat.full)
		else $error("job pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("front not busy after accepting a word");
`endif

endmodule
